/* design/cp_pkg.sv */
// ----------------------------------------------------------------------------
// cp_pkg
// Shared constants for the closest pair search block.
// ----------------------------------------------------------------------------
package cp_pkg;

  localparam int MAX_POINTS_DEF = 512;
  localparam int COORD_BITS_DEF = 16;

  localparam int DIST_W = 34;
  localparam int IDX_W  = 9;

  localparam logic [DIST_W-1:0] DIST_MAX      = 34'h3_FFFF_FFFF;
  localparam logic [DIST_W-1:0] DEFAULT_BOUND = 34'd20000;
  localparam logic [31:0]       SQRT_LIMIT    = 32'd131072;

endpackage

/* design/cp_store.sv */
// ----------------------------------------------------------------------------
// cp_store
// Point memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cp_store #(
  parameter int DEPTH = cp_pkg::MAX_POINTS_DEF,
  parameter int DW    = 2 * cp_pkg::COORD_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* design/cp_dist.sv */
// ----------------------------------------------------------------------------
// cp_dist
// Squared distance unit: one shared squarer, result registered in dist_r with done_r
// after the phase registers, saturating at the result range.
// ----------------------------------------------------------------------------
module cp_dist #(
  parameter int COORD_BITS = cp_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [2*COORD_BITS-1:0]   pt_a,
  input  logic [2*COORD_BITS-1:0]   pt_b,
  output logic                      done_r,
  output logic [cp_pkg::DIST_W-1:0] dist_r
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C;
  localparam int SW = PW + 1;

  logic [C:0]    dx_d, dy_d, dx_m, dy_m;
  logic [C-1:0]  dx_r, dy_r, sq_op;
  logic          big_r;
  logic [2:0]    ph_r;
  logic [PW-1:0] prod_r, acc_r, sq_res;
  logic [SW-1:0] sum;

  always_comb begin
    dx_d = {pt_a[PW-1], pt_a[PW-1:C]} - {pt_b[PW-1], pt_b[PW-1:C]};
    dy_d = {pt_a[C-1], pt_a[C-1:0]} - {pt_b[C-1], pt_b[C-1:0]};
    dx_m = dx_d[C] ? (~dx_d + 1'b1) : dx_d;
    dy_m = dy_d[C] ? (~dy_d + 1'b1) : dy_d;
  end

  assign sq_op  = ph_r[1] ? dy_r : dx_r;
  assign sq_res = PW'(sq_op) * PW'(sq_op);
  assign sum    = SW'(acc_r) + SW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= {ph_r[1:0], start};
      done_r <= ph_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dx_r  <= dx_m[C-1:0];
      dy_r  <= dy_m[C-1:0];
      big_r <= (32'(dx_m[C-1:0]) >= cp_pkg::SQRT_LIMIT) ||
               (32'(dy_m[C-1:0]) >= cp_pkg::SQRT_LIMIT);
    end
    if (ph_r[0]) begin
      prod_r <= sq_res;
    end
    if (ph_r[1]) begin
      acc_r  <= prod_r;
      prod_r <= sq_res;
    end
    if (ph_r[2]) begin
      dist_r <= (big_r || (64'(sum) > 64'(cp_pkg::DIST_MAX))) ?
                cp_pkg::DIST_MAX : cp_pkg::DIST_W'(sum);
    end
  end

endmodule

/* design/closest_pair_brute_force.sv */
// Load: one point per cycle while idle; in_stall is low only while loading.
// Search: each pair runs S_LATJ and S_WAIT through the shared squarer, and
//   each outer row first runs S_RDI and S_LATI; out_valid follows the last row.
// A duplicate pair ends the search at once. One search at a time.
// Reset: synchronous, clears the point count and the sequencer; the bound
//   register returns to 20000. The point memory is not cleared.
// ----------------------------------------------------------------------------
// closest_pair_brute_force
// Brute force closest pair search over a stored point set, exact squared
// integer distance, strict minimum from a configurable bound.
// ----------------------------------------------------------------------------
module closest_pair_brute_force #(
  parameter int MAX_POINTS = cp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [cp_pkg::DIST_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_x_coord,
  input  logic signed [COORD_BITS-1:0] in_y_coord,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cp_pkg::DIST_W-1:0]    out_min_dist_sq,
  output logic [cp_pkg::IDX_W-1:0]     out_first_index,
  output logic [cp_pkg::IDX_W-1:0]     out_second_index,
  output logic                         out_duplicate_found
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = 2 * COORD_BITS;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_RDI  = 6'b000010,
    S_LATI = 6'b000100,
    S_LATJ = 6'b001000,
    S_WAIT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [cp_pkg::DIST_W-1:0] bound_r, best_r;
  logic [CW-1:0]             cnt_r, n_r, i_r, j_r, cnt_inc;
  logic [AW-1:0]             bi_r, bj_r;
  logic                      dup_r;
  logic [DW-1:0]             pi_r, rd_data_r;
  logic [AW-1:0]             rd_addr;
  logic                      in_xfer, out_xfer, wr_en, room;
  logic                      dist_start, dist_done;
  logic [cp_pkg::DIST_W-1:0] pair_dist;
  logic                      row_end, pair_eq;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign room     = cnt_r < CW'(MAX_POINTS);
  assign wr_en    = in_xfer && room;
  assign cnt_inc  = room ? cnt_r + CW'(1) : cnt_r;
  assign row_end  = (j_r + CW'(1)) >= n_r;
  assign pair_eq  = (pi_r == rd_data_r);

  assign in_stall   = (state_r != S_LOAD);
  assign out_valid  = (state_r == S_OUT);
  assign dist_start = (state_r == S_LATJ) && !pair_eq;

  assign out_min_dist_sq     = best_r;
  assign out_first_index     = cp_pkg::IDX_W'(bi_r);
  assign out_second_index    = cp_pkg::IDX_W'(bj_r);
  assign out_duplicate_found = dup_r;

  always_comb begin
    unique case (state_r)
      S_LATI:  rd_addr = j_r[AW-1:0];
      S_WAIT:  rd_addr = AW'(j_r + CW'(1));
      default: rd_addr = i_r[AW-1:0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer && in_last_point) state_nxt = S_RDI;
      end
      S_RDI: begin
        state_nxt = ((i_r + CW'(1)) >= n_r) ? S_OUT : S_LATI;
      end
      S_LATI: state_nxt = S_LATJ;
      S_LATJ: state_nxt = pair_eq ? S_OUT : S_WAIT;
      S_WAIT: begin
        if (dist_done) state_nxt = row_end ? S_RDI : S_LATJ;
      end
      S_OUT: begin
        if (out_xfer) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      bound_r <= cp_pkg::DEFAULT_BOUND;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        bound_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        cnt_r <= cnt_inc;
      end else if (out_xfer) begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer && in_last_point) begin
          n_r    <= cnt_inc;
          best_r <= bound_r;
          bi_r   <= '0;
          bj_r   <= '0;
          dup_r  <= 1'b0;
          i_r    <= '0;
        end
      end
      S_RDI: begin
        j_r <= i_r + CW'(1);
      end
      S_LATI: begin
        pi_r <= rd_data_r;
      end
      S_LATJ: begin
        if (pair_eq) begin
          dup_r  <= 1'b1;
          best_r <= '0;
          bi_r   <= '0;
          bj_r   <= '0;
        end
      end
      S_WAIT: begin
        if (dist_done) begin
          if (pair_dist < best_r) begin
            best_r <= pair_dist;
            bi_r   <= i_r[AW-1:0];
            bj_r   <= j_r[AW-1:0];
          end
          if (row_end) begin
            i_r <= i_r + CW'(1);
          end else begin
            j_r <= j_r + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  cp_store #(
    .DEPTH (MAX_POINTS),
    .DW    (DW),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (cnt_r[AW-1:0]),
    .wr_data   ({in_x_coord, in_y_coord}),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  cp_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dist_start),
    .pt_a   (pi_r),
    .pt_b   (rd_data_r),
    .done_r (dist_done),
    .dist_r (pair_dist)
  );

endmodule

/* design/cp_checker.sv */
// ----------------------------------------------------------------------------
// cp_checker
// Port level checks for the closest pair search block.
// ----------------------------------------------------------------------------
module cp_checker #(
  parameter int COORD_BITS = cp_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_wr_en,
  input logic [cp_pkg::DIST_W-1:0]    cfg_wr_data,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [COORD_BITS-1:0] in_x_coord,
  input logic signed [COORD_BITS-1:0] in_y_coord,
  input logic                         in_last_point,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [cp_pkg::DIST_W-1:0]    out_min_dist_sq,
  input logic [cp_pkg::IDX_W-1:0]     out_first_index,
  input logic [cp_pkg::IDX_W-1:0]     out_second_index,
  input logic                         out_duplicate_found
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_dist_sq) &&
    $stable(out_first_index) && $stable(out_second_index) &&
    $stable(out_duplicate_found))
    else $error("stalled result changed");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_point |=> in_stall)
    else $error("last point did not start the search");

  a_dup_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_duplicate_found |-> out_min_dist_sq == '0 &&
    out_first_index == '0 && out_second_index == '0)
    else $error("duplicate result not zeroed");

endmodule

bind closest_pair_brute_force cp_checker #(.COORD_BITS(COORD_BITS)) u_cp_checker (.*);
